// File: rtl/core/ihp_pkg.sv
// Shared types and constants for the IPv4 TCP/UDP header parser.
// Holds the per-frame capture record that moves from the front to the back.
// No dependencies.
package ihp_pkg;

	localparam int LINK_HDR_LEN_DEF = 14;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] PROTO_TCP_NUM = 8'd6;
	localparam logic [7:0] PROTO_UDP_NUM = 8'd17;

	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_TCP = 2'd1;
	localparam logic [1:0] KIND_UDP = 2'd2;
	localparam logic [1:0] KIND_TRUNC = 2'd3;

	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [16:0] MIN_IP_BYTES = 17'd20;
	localparam logic [16:0] MIN_TCP_BYTES = 17'd20;
	localparam logic [16:0] MIN_UDP_BYTES = 17'd8;

	typedef struct packed {
		logic [5:0]  ihl;
		logic [7:0]  proto;
		logic [5:0]  tcp_off;
		logic        ack_seen;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  ttl;
		logic [15:0] tlen;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  flags;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] win;
	} frame_cap_t;

	typedef struct packed {
		logic [16:0] flen;
		logic [1:0]  kind;
		frame_cap_t  cap;
	} hdr_rec_t;

endpackage

// File: rtl/core/ihp_front.sv
// Front end of the header parser: accepts one frame byte per request and
// captures the IPv4 and transport header fields. Pushes a record on the last byte.
// Depends on ihp_pkg.
module ihp_front #(
	parameter int LINK_HDR_LEN = ihp_pkg::LINK_HDR_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             frame_last,
	input  logic             q_full,
	output logic             push,
	output ihp_pkg::hdr_rec_t push_rec
);
	import ihp_pkg::*;

	localparam logic [15:0] LinkLen = 16'(LINK_HDR_LEN);

	logic [15:0] idx_q;
	frame_cap_t  cap_q;
	frame_cap_t  cap_n;
	logic [15:0] p;
	logic [15:0] t;
	logic [5:0]  ihl_eff;
	logic        accept;

	assign in_stall = q_full;
	assign accept = in_valid && !in_stall;
	assign push = accept && frame_last;

	always_comb begin
		cap_n = cap_q;
		p = idx_q - LinkLen;
		t = '0;
		ihl_eff = cap_q.ihl;
		if (idx_q >= LinkLen) begin
			if (p == 16'd0) begin
				cap_n.ihl = {data_byte[3:0], 2'b00};
				ihl_eff = cap_n.ihl;
			end else if (p == 16'd2) begin
				cap_n.tlen[15:8] = data_byte;
			end else if (p == 16'd3) begin
				cap_n.tlen[7:0] = data_byte;
			end else if (p == 16'd8) begin
				cap_n.ttl = data_byte;
			end else if (p == 16'd9) begin
				cap_n.proto = data_byte;
			end else if (p >= 16'd12 && p < 16'd16) begin
				cap_n.src[{~p[1:0], 3'b000} +: 8] = data_byte;
			end else if (p >= 16'd16 && p < 16'd20) begin
				cap_n.dst[{~p[1:0], 3'b000} +: 8] = data_byte;
			end
			if (p >= {10'd0, ihl_eff}) begin
				t = p - {10'd0, ihl_eff};
				if (t < 16'd2) begin
					cap_n.sport[{~t[0], 3'b000} +: 8] = data_byte;
				end else if (t < 16'd4) begin
					cap_n.dport[{~t[0], 3'b000} +: 8] = data_byte;
				end else if (t < 16'd8) begin
					cap_n.seq[{~t[1:0], 3'b000} +: 8] = data_byte;
				end else if (t < 16'd12) begin
					cap_n.ack[{~t[1:0], 3'b000} +: 8] = data_byte;
				end else if (t == 16'd12) begin
					cap_n.tcp_off = {data_byte[7:4], 2'b00};
				end else if (t == 16'd13) begin
					cap_n.flags = data_byte;
					cap_n.ack_seen = data_byte[4];
				end else if (t < 16'd16) begin
					cap_n.win[{~t[0], 3'b000} +: 8] = data_byte;
				end
			end
		end
	end

	always_comb begin
		push_rec.flen = {1'b0, idx_q} + 17'd1;
		push_rec.cap = cap_n;
		if (cap_n.proto == PROTO_TCP_NUM) begin
			push_rec.kind = KIND_TCP;
		end else if (cap_n.proto == PROTO_UDP_NUM) begin
			push_rec.kind = KIND_UDP;
		end else begin
			push_rec.kind = KIND_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cap_q <= '0;
		end else if (accept) begin
			if (frame_last) begin
				idx_q <= '0;
				cap_q <= '0;
			end else begin
				idx_q <= (idx_q == 16'hFFFF) ? idx_q : idx_q + 16'd1;
				cap_q <= cap_n;
			end
		end
	end

endmodule

// File: rtl/core/ihp_queue.sv
// Short queue of frame records between the front and the back of the parser.
// Depth is a power of two taken from the package.
// Depends on ihp_pkg.
module ihp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ihp_pkg::hdr_rec_t push_rec,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output ihp_pkg::hdr_rec_t q_rec
);
	import ihp_pkg::*;

	hdr_rec_t              entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_rec = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/ihp_back.sv
// Back end of the header parser: turns a frame record into the summary result,
// checks for truncation, computes the payload length and holds the output register.
// Depends on ihp_pkg.
module ihp_back #(
	parameter int LINK_HDR_LEN = ihp_pkg::LINK_HDR_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  ihp_pkg::hdr_rec_t q_rec,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       protocol,
	output logic [31:0]      source_ip,
	output logic [31:0]      dest_ip,
	output logic [7:0]       ttl,
	output logic [15:0]      total_len,
	output logic [5:0]       ip_hdr_len,
	output logic [15:0]      source_port,
	output logic [15:0]      dest_port,
	output logic [15:0]      payload_len,
	output logic [31:0]      seq_no,
	output logic [31:0]      ack_no,
	output logic [20:0]      tcp_ctrl
);
	import ihp_pkg::*;

	localparam logic [16:0] LinkLen = 17'(LINK_HDR_LEN);

	logic        load;
	logic        is_tcp;
	logic        is_udp;
	logic        trunc;
	logic [16:0] tp_base;
	logic [15:0] ip_rem;
	logic [15:0] tp_len;
	logic [15:0] pay_len;

	logic [1:0]  protocol_n;
	logic [31:0] source_ip_n;
	logic [31:0] dest_ip_n;
	logic [7:0]  ttl_n;
	logic [15:0] total_len_n;
	logic [5:0]  ip_hdr_len_n;
	logic [15:0] source_port_n;
	logic [15:0] dest_port_n;
	logic [15:0] payload_len_n;
	logic [31:0] seq_no_n;
	logic [31:0] ack_no_n;
	logic [20:0] tcp_ctrl_n;

	logic        out_valid_q;
	logic [1:0]  protocol_q;
	logic [31:0] source_ip_q;
	logic [31:0] dest_ip_q;
	logic [7:0]  ttl_q;
	logic [15:0] total_len_q;
	logic [5:0]  ip_hdr_len_q;
	logic [15:0] source_port_q;
	logic [15:0] dest_port_q;
	logic [15:0] payload_len_q;
	logic [31:0] seq_no_q;
	logic [31:0] ack_no_q;
	logic [20:0] tcp_ctrl_q;

	assign load = !out_valid_q || !out_stall;
	assign pop = q_valid && load;

	assign is_tcp = (q_rec.kind == KIND_TCP);
	assign is_udp = (q_rec.kind == KIND_UDP);
	assign tp_base = LinkLen + {11'd0, q_rec.cap.ihl};

	always_comb begin
		trunc = (q_rec.flen < LinkLen + MIN_IP_BYTES);
		if (is_tcp && q_rec.flen < tp_base + MIN_TCP_BYTES) begin
			trunc = 1'b1;
		end
		if (is_udp && q_rec.flen < tp_base + MIN_UDP_BYTES) begin
			trunc = 1'b1;
		end
		ip_rem = (q_rec.cap.tlen > {10'd0, q_rec.cap.ihl}) ?
			q_rec.cap.tlen - {10'd0, q_rec.cap.ihl} : '0;
		tp_len = is_tcp ? {10'd0, q_rec.cap.tcp_off} : UDP_HDR_BYTES;
		pay_len = (ip_rem > tp_len) ? ip_rem - tp_len : '0;
	end

	always_comb begin
		protocol_n = KIND_UNKNOWN;
		source_ip_n = '0;
		dest_ip_n = '0;
		ttl_n = '0;
		total_len_n = '0;
		ip_hdr_len_n = '0;
		source_port_n = '0;
		dest_port_n = '0;
		payload_len_n = '0;
		seq_no_n = '0;
		ack_no_n = '0;
		tcp_ctrl_n = '0;
		if (trunc) begin
			protocol_n = KIND_TRUNC;
		end else begin
			protocol_n = q_rec.kind;
			source_ip_n = q_rec.cap.src;
			dest_ip_n = q_rec.cap.dst;
			ttl_n = q_rec.cap.ttl;
			total_len_n = q_rec.cap.tlen;
			ip_hdr_len_n = q_rec.cap.ihl;
			if (is_tcp || is_udp) begin
				source_port_n = q_rec.cap.sport;
				dest_port_n = q_rec.cap.dport;
				payload_len_n = pay_len;
			end
			if (is_tcp) begin
				seq_no_n = q_rec.cap.seq;
				ack_no_n = q_rec.cap.ack_seen ? q_rec.cap.ack : '0;
				tcp_ctrl_n = {q_rec.cap.flags[5], q_rec.cap.flags[3],
					q_rec.cap.flags[2], q_rec.cap.flags[1], q_rec.cap.flags[0],
					q_rec.cap.win};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			protocol_q <= protocol_n;
			source_ip_q <= source_ip_n;
			dest_ip_q <= dest_ip_n;
			ttl_q <= ttl_n;
			total_len_q <= total_len_n;
			ip_hdr_len_q <= ip_hdr_len_n;
			source_port_q <= source_port_n;
			dest_port_q <= dest_port_n;
			payload_len_q <= payload_len_n;
			seq_no_q <= seq_no_n;
			ack_no_q <= ack_no_n;
			tcp_ctrl_q <= tcp_ctrl_n;
		end
	end

	assign out_valid = out_valid_q;
	assign protocol = protocol_q;
	assign source_ip = source_ip_q;
	assign dest_ip = dest_ip_q;
	assign ttl = ttl_q;
	assign total_len = total_len_q;
	assign ip_hdr_len = ip_hdr_len_q;
	assign source_port = source_port_q;
	assign dest_port = dest_port_q;
	assign payload_len = payload_len_q;
	assign seq_no = seq_no_q;
	assign ack_no = ack_no_q;
	assign tcp_ctrl = tcp_ctrl_q;

endmodule

// File: rtl/core/ipv4_tcp_udp_header_parser.sv
// Top level of the IPv4 TCP/UDP header parser.
// Instantiates ihp_front, ihp_queue and ihp_back; depends on ihp_pkg.
//
// The parser takes one frame byte per clock and never stalls the input while its
// two-entry record queue has room. On the request that carries the last byte of a
// frame the front pushes a record into the queue; the back then writes its summary
// into the output register once the output is not stalling. The input stalls only
// when both queue entries are held because the output side is stalling.
module ipv4_tcp_udp_header_parser #(
	parameter int LINK_HDR_LEN = ihp_pkg::LINK_HDR_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  protocol,
	output logic [31:0] source_ip,
	output logic [31:0] dest_ip,
	output logic [7:0]  ttl,
	output logic [15:0] total_len,
	output logic [5:0]  ip_hdr_len,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [15:0] payload_len,
	output logic [31:0] seq_no,
	output logic [31:0] ack_no,
	output logic [20:0] tcp_ctrl
);
	import ihp_pkg::*;

	logic     q_full;
	logic     push;
	hdr_rec_t push_rec;
	logic     pop;
	logic     q_valid;
	hdr_rec_t q_rec;

	ihp_front #(
		.LINK_HDR_LEN(LINK_HDR_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.frame_last(frame_last),
		.q_full(q_full),
		.push(push),
		.push_rec(push_rec)
	);

	ihp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_rec(push_rec),
		.full(q_full),
		.pop(pop),
		.q_valid(q_valid),
		.q_rec(q_rec)
	);

	ihp_back #(
		.LINK_HDR_LEN(LINK_HDR_LEN)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_rec(q_rec),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.protocol(protocol),
		.source_ip(source_ip),
		.dest_ip(dest_ip),
		.ttl(ttl),
		.total_len(total_len),
		.ip_hdr_len(ip_hdr_len),
		.source_port(source_port),
		.dest_port(dest_port),
		.payload_len(payload_len),
		.seq_no(seq_no),
		.ack_no(ack_no),
		.tcp_ctrl(tcp_ctrl)
	);

endmodule
